// ===== sv/ssi_pkg.sv =====
// shared types and default constants for the segment intersection block
// no dependencies
`timescale 1ns / 1ps

package ssi_pkg;

    localparam int COORD_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;

    typedef struct packed {
        logic valid;
        logic hit;
    } t_ctl;

endpackage

// ===== sv/ssi_front.sv =====
// front pipeline: differences, products, cross products, range checks, magnitudes
// four stages with per-stage valid and bubble-filling ready; uses ssi_pkg
`timescale 1ns / 1ps

module ssi_front #(
    parameter int COORD_BITS = ssi_pkg::COORD_BITS_DEF,
    parameter int MW         = 2 * (COORD_BITS + 1) + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [COORD_BITS-1:0] i_first_start_x,
    input  logic signed [COORD_BITS-1:0] i_first_start_y,
    input  logic signed [COORD_BITS-1:0] i_first_end_x,
    input  logic signed [COORD_BITS-1:0] i_first_end_y,
    input  logic signed [COORD_BITS-1:0] i_second_start_x,
    input  logic signed [COORD_BITS-1:0] i_second_start_y,
    input  logic signed [COORD_BITS-1:0] i_second_end_x,
    input  logic signed [COORD_BITS-1:0] i_second_end_y,
    input  logic                         i_ready,
    output ssi_pkg::t_ctl                o_ctl,
    output logic        [MW-1:0]         o_mag_d,
    output logic        [MW-1:0]         o_mag_n1,
    output logic        [MW-1:0]         o_mag_n2
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;

    logic rdy1, rdy2, rdy3, rdy4;
    logic r_v1, r_v2, r_v3, r_v4;

    logic signed [DW-1:0] r_vx, r_vy, r_sx, r_sy, r_dx, r_dy;
    logic signed [DW-1:0] n_vx, n_vy, n_sx, n_sy, n_dx, n_dy;
    logic signed [PW-1:0] r_p_vs, r_p_ys, r_p_ds, r_p_es, r_p_dv, r_p_ev;
    logic signed [PW-1:0] n_p_vs, n_p_ys, n_p_ds, n_p_es, n_p_dv, n_p_ev;
    logic signed [XW-1:0] r_den, r_n1, r_n2;
    logic signed [XW-1:0] n_den, n_n1, n_n2;
    logic                 r_hit, n_hit;
    logic        [MW-1:0] r_md, r_m1, r_m2;
    logic        [MW-1:0] n_md, n_m1, n_m2;

    function automatic logic in_unit(input logic signed [XW-1:0] num,
                                     input logic signed [XW-1:0] den);
        logic pos;
        pos = (den > 0);
        if (pos) begin
            return (num >= 0) && (num <= den);
        end
        return (num <= 0) && (num >= den);
    endfunction

    function automatic logic [MW-1:0] mag(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] neg;
        neg = -x;
        return x[XW-1] ? MW'(neg) : MW'(x);
    endfunction

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        n_vx = DW'(i_first_end_x) - DW'(i_first_start_x);
        n_vy = DW'(i_first_end_y) - DW'(i_first_start_y);
        n_sx = DW'(i_second_end_x) - DW'(i_second_start_x);
        n_sy = DW'(i_second_end_y) - DW'(i_second_start_y);
        n_dx = DW'(i_second_start_x) - DW'(i_first_start_x);
        n_dy = DW'(i_second_start_y) - DW'(i_first_start_y);

        n_p_vs = PW'(r_vx) * PW'(r_sy);
        n_p_ys = PW'(r_vy) * PW'(r_sx);
        n_p_ds = PW'(r_dx) * PW'(r_sy);
        n_p_es = PW'(r_dy) * PW'(r_sx);
        n_p_dv = PW'(r_dx) * PW'(r_vy);
        n_p_ev = PW'(r_dy) * PW'(r_vx);

        n_den = XW'(r_p_vs) - XW'(r_p_ys);
        n_n1  = XW'(r_p_ds) - XW'(r_p_es);
        n_n2  = XW'(r_p_dv) - XW'(r_p_ev);

        n_hit = (r_den != '0) && in_unit(r_n1, r_den) && in_unit(r_n2, r_den);
        n_md  = mag(r_den);
        n_m1  = mag(r_n1);
        n_m2  = mag(r_n2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_vx <= n_vx;
            r_vy <= n_vy;
            r_sx <= n_sx;
            r_sy <= n_sy;
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
        if (rdy2) begin
            r_p_vs <= n_p_vs;
            r_p_ys <= n_p_ys;
            r_p_ds <= n_p_ds;
            r_p_es <= n_p_es;
            r_p_dv <= n_p_dv;
            r_p_ev <= n_p_ev;
        end
        if (rdy3) begin
            r_den <= n_den;
            r_n1  <= n_n1;
            r_n2  <= n_n2;
        end
        if (rdy4) begin
            r_hit <= n_hit;
            r_md  <= n_md;
            r_m1  <= n_m1;
            r_m2  <= n_m2;
        end
    end

    always_comb begin
        o_ctl.valid = r_v4;
        o_ctl.hit   = r_hit;
    end

    assign o_mag_d  = r_md;
    assign o_mag_n1 = r_m1;
    assign o_mag_n2 = r_m2;

endmodule

// ===== sv/ssi_div_cell.sv =====
// one restoring division step for both parameters, registered
// cells chain into a quotient pipeline; uses ssi_pkg
`timescale 1ns / 1ps

module ssi_div_cell #(
    parameter int MW = 2 * (ssi_pkg::COORD_BITS_DEF + 1) + 1,
    parameter int QW = ssi_pkg::FRACTION_BITS_DEF + 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ssi_pkg::t_ctl i_ctl,
    output logic          o_ready,
    input  logic [MW-1:0] i_d,
    input  logic [MW:0]   i_rem1,
    input  logic [MW:0]   i_rem2,
    input  logic [QW-1:0] i_q1,
    input  logic [QW-1:0] i_q2,
    input  logic          i_ready,
    output ssi_pkg::t_ctl o_ctl,
    output logic [MW-1:0] o_d,
    output logic [MW:0]   o_rem1,
    output logic [MW:0]   o_rem2,
    output logic [QW-1:0] o_q1,
    output logic [QW-1:0] o_q2
);

    logic          r_valid;
    logic          r_hit;
    logic [MW-1:0] r_d;
    logic [MW:0]   r_rem1, r_rem2, n_rem1, n_rem2;
    logic [QW-1:0] r_q1, r_q2, n_q1, n_q2;
    logic [MW:0]   dx, left1, left2;
    logic          t1, t2;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        dx     = {1'b0, i_d};
        t1     = (i_rem1 >= dx);
        t2     = (i_rem2 >= dx);
        left1  = t1 ? (i_rem1 - dx) : i_rem1;
        left2  = t2 ? (i_rem2 - dx) : i_rem2;
        n_rem1 = {left1[MW-1:0], 1'b0};
        n_rem2 = {left2[MW-1:0], 1'b0};
        n_q1   = {i_q1[QW-2:0], t1};
        n_q2   = {i_q2[QW-2:0], t2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_hit  <= i_ctl.hit;
            r_d    <= i_d;
            r_rem1 <= n_rem1;
            r_rem2 <= n_rem2;
            r_q1   <= n_q1;
            r_q2   <= n_q2;
        end
    end

    always_comb begin
        o_ctl.valid = r_valid;
        o_ctl.hit   = r_hit;
    end

    assign o_d    = r_d;
    assign o_rem1 = r_rem1;
    assign o_rem2 = r_rem2;
    assign o_q1   = r_q1;
    assign o_q2   = r_q2;

endmodule

// ===== sv/segment_segment_intersection.sv =====
// segment intersection top: front pipeline followed by a chain of division cells
// path: a request passes through the front pipeline, then through each division cell, to the result
// throughput: one request per cycle while i_stall is low; each stage moves on when its successor frees
// the division chain yields one quotient bit per cell, FRACTION_BITS + 1 cells
// reset clears only the stage valid bits; depends on ssi_pkg, ssi_front, ssi_div_cell
`timescale 1ns / 1ps

module segment_segment_intersection #(
    parameter int COORD_BITS    = ssi_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = ssi_pkg::FRACTION_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_first_start_x,
    input  logic signed [COORD_BITS-1:0] i_first_start_y,
    input  logic signed [COORD_BITS-1:0] i_first_end_x,
    input  logic signed [COORD_BITS-1:0] i_first_end_y,
    input  logic signed [COORD_BITS-1:0] i_second_start_x,
    input  logic signed [COORD_BITS-1:0] i_second_start_y,
    input  logic signed [COORD_BITS-1:0] i_second_end_x,
    input  logic signed [COORD_BITS-1:0] i_second_end_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit,
    output logic [FRACTION_BITS+1:0]     o_first_param,
    output logic [FRACTION_BITS+1:0]     o_second_param
);

    localparam int MW = 2 * (COORD_BITS + 1) + 1;
    localparam int QW = FRACTION_BITS + 2;
    localparam int NC = FRACTION_BITS + 1;
    localparam logic [QW-1:0] MISS = {2'b10, {FRACTION_BITS{1'b0}}};
    localparam logic [QW-1:0] ONE  = {2'b01, {FRACTION_BITS{1'b0}}};

    ssi_pkg::t_ctl c_ctl   [NC+1];
    logic          c_ready [NC+1];
    logic [MW-1:0] c_d     [NC+1];
    logic [MW:0]   c_rem1  [NC+1];
    logic [MW:0]   c_rem2  [NC+1];
    logic [QW-1:0] c_q1    [NC+1];
    logic [QW-1:0] c_q2    [NC+1];
    logic [MW-1:0] mag_n1, mag_n2;
    logic          front_ready;

    ssi_front #(
        .COORD_BITS (COORD_BITS),
        .MW         (MW)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (front_ready),
        .i_first_start_x  (i_first_start_x),
        .i_first_start_y  (i_first_start_y),
        .i_first_end_x    (i_first_end_x),
        .i_first_end_y    (i_first_end_y),
        .i_second_start_x (i_second_start_x),
        .i_second_start_y (i_second_start_y),
        .i_second_end_x   (i_second_end_x),
        .i_second_end_y   (i_second_end_y),
        .i_ready          (c_ready[0]),
        .o_ctl            (c_ctl[0]),
        .o_mag_d          (c_d[0]),
        .o_mag_n1         (mag_n1),
        .o_mag_n2         (mag_n2)
    );

    assign c_rem1[0] = {1'b0, mag_n1};
    assign c_rem2[0] = {1'b0, mag_n2};
    assign c_q1[0]   = '0;
    assign c_q2[0]   = '0;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        ssi_div_cell #(
            .MW (MW),
            .QW (QW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (c_ctl[k]),
            .o_ready (c_ready[k]),
            .i_d     (c_d[k]),
            .i_rem1  (c_rem1[k]),
            .i_rem2  (c_rem2[k]),
            .i_q1    (c_q1[k]),
            .i_q2    (c_q2[k]),
            .i_ready (c_ready[k+1]),
            .o_ctl   (c_ctl[k+1]),
            .o_d     (c_d[k+1]),
            .o_rem1  (c_rem1[k+1]),
            .o_rem2  (c_rem2[k+1]),
            .o_q1    (c_q1[k+1]),
            .o_q2    (c_q2[k+1])
        );
    end

    assign c_ready[NC]    = !i_stall;
    assign o_stall        = !front_ready;
    assign o_valid        = c_ctl[NC].valid;
    assign o_hit          = c_ctl[NC].hit;
    assign o_first_param  = c_ctl[NC].hit ? c_q1[NC] : MISS;
    assign o_second_param = c_ctl[NC].hit ? c_q2[NC] : MISS;

`ifndef SYNTHESIS
    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (o_first_param <= ONE && o_second_param <= ONE))
        else $error("hit result above 1.0");

    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_first_param == MISS && o_second_param == MISS))
        else $error("miss result not 2.0");

    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output drains");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");
`endif

endmodule

// ===== dv/segment_segment_intersection_tb.sv =====
// testbench for segment_segment_intersection: directed and random segment pairs,
// each result checked against an in-bench exact-integer prediction of t1, t2 and hit
// depends on ssi_pkg and segment_segment_intersection
`timescale 1ns / 1ps

module segment_segment_intersection_tb;

    localparam int COORD_BITS    = ssi_pkg::COORD_BITS_DEF;
    localparam int FRACTION_BITS = ssi_pkg::FRACTION_BITS_DEF;
    localparam int PARAM_W       = FRACTION_BITS + 2;
    localparam int MAX_WAIT      = 11;
    localparam int SETTLE_CYCLES = 40;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [PARAM_W-1:0]    t_param;

    localparam t_param MISS_PARAM = t_param'(2) << FRACTION_BITS;

    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
        t_coord cx;
        t_coord cy;
        t_coord ex;
        t_coord ey;
    } t_seg_pair;

    typedef struct packed {
        logic   hit;
        t_param t1;
        t_param t2;
    } t_crossing;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_stall;
    t_coord i_first_start_x;
    t_coord i_first_start_y;
    t_coord i_first_end_x;
    t_coord i_first_end_y;
    t_coord i_second_start_x;
    t_coord i_second_start_y;
    t_coord i_second_end_x;
    t_coord i_second_end_y;
    logic   o_valid;
    logic   i_stall;
    logic   o_hit;
    t_param o_first_param;
    t_param o_second_param;

    t_crossing crossing_q[$];
    int        mismatch_count;
    bit        idle_on;

    segment_segment_intersection #(
        .COORD_BITS   (COORD_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_first_start_x (i_first_start_x),
        .i_first_start_y (i_first_start_y),
        .i_first_end_x   (i_first_end_x),
        .i_first_end_y   (i_first_end_y),
        .i_second_start_x(i_second_start_x),
        .i_second_start_y(i_second_start_y),
        .i_second_end_x  (i_second_end_x),
        .i_second_end_y  (i_second_end_y),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hit           (o_hit),
        .o_first_param   (o_first_param),
        .o_second_param  (o_second_param)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_crossing predict_crossing(input t_seg_pair r);
        longint vx, vy, sx, sy, dx, dy;
        longint den, n1, n2;
        longint unsigned dm, m1, m2;
        bit inside_both;
        t_crossing res;
        vx = longint'($signed(r.bx)) - longint'($signed(r.ax));
        vy = longint'($signed(r.by)) - longint'($signed(r.ay));
        sx = longint'($signed(r.ex)) - longint'($signed(r.cx));
        sy = longint'($signed(r.ey)) - longint'($signed(r.cy));
        dx = longint'($signed(r.cx)) - longint'($signed(r.ax));
        dy = longint'($signed(r.cy)) - longint'($signed(r.ay));
        den = vx * sy - vy * sx;
        n1  = dx * sy - dy * sx;
        n2  = dx * vy - dy * vx;
        if (den > 0)
            inside_both = (n1 >= 0) && (n1 <= den) && (n2 >= 0) && (n2 <= den);
        else
            inside_both = (n1 <= 0) && (n1 >= den) && (n2 <= 0) && (n2 >= den);
        if (den == 0 || !inside_both) begin
            res.hit = 1'b0;
            res.t1  = MISS_PARAM;
            res.t2  = MISS_PARAM;
        end else begin
            dm = (den < 0) ? longint'(-den) : longint'(den);
            m1 = (n1 < 0) ? longint'(-n1) : longint'(n1);
            m2 = (n2 < 0) ? longint'(-n2) : longint'(n2);
            res.hit = 1'b1;
            res.t1  = t_param'((m1 << FRACTION_BITS) / dm);
            res.t2  = t_param'((m2 << FRACTION_BITS) / dm);
        end
        return res;
    endfunction

    function automatic t_seg_pair seg(input int ax, input int ay, input int bx, input int by,
                                      input int cx, input int cy, input int ex, input int ey);
        t_seg_pair r;
        r.ax = t_coord'(ax);
        r.ay = t_coord'(ay);
        r.bx = t_coord'(bx);
        r.by = t_coord'(by);
        r.cx = t_coord'(cx);
        r.cy = t_coord'(cy);
        r.ex = t_coord'(ex);
        r.ey = t_coord'(ey);
        return r;
    endfunction

    function automatic t_coord rand_coord(input bit wide);
        if (wide)
            return t_coord'($urandom);
        return t_coord'($urandom_range(0, 127) - 64);
    endfunction

    task automatic send_request(input t_seg_pair r);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_first_start_x  <= r.ax;
        i_first_start_y  <= r.ay;
        i_first_end_x    <= r.bx;
        i_first_end_y    <= r.by;
        i_second_start_x <= r.cx;
        i_second_start_y <= r.cy;
        i_second_end_x   <= r.ex;
        i_second_end_y   <= r.ey;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        crossing_q = {crossing_q, predict_crossing(r)};
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (crossing_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_hits();
        send_request(seg(0, 0, 10, 10, 0, 10, 10, 0));
        send_request(seg(0, 10, 10, 0, 0, 0, 10, 10));
        // touching at the first segment's end
        send_request(seg(0, 0, 10, 0, 10, -5, 10, 5));
        // second segment ends on the first
        send_request(seg(-10, 0, 10, 0, 0, -5, 0, 0));
        // both starts coincide
        send_request(seg(0, 0, 10, 0, 0, 0, 0, 10));
        // truncated thirds
        send_request(seg(0, 0, 3, 0, 1, -1, 1, 2));
        send_request(seg(7, -3, -5, 9, -6, -4, 8, 6));
    endtask

    task automatic test_directed_misses();
        send_request(seg(0, 0, 10, 0, 0, 5, 10, 5));
        send_request(seg(0, 0, 10, 0, 5, 0, 20, 0));
        send_request(seg(3, 3, 3, 3, 3, 3, 3, 3));
        send_request(seg(0, 0, 0, 0, -5, 0, 5, 0));
        send_request(seg(0, 0, 10, 0, 20, -5, 20, 5));
        send_request(seg(0, 0, 10, 0, -5, -5, -5, 5));
        send_request(seg(0, 0, 10, 0, 5, 1, 5, 10));
        send_request(seg(0, 0, 10, 0, 5, -10, 5, -1));
    endtask

    task automatic test_coordinate_extremes();
        send_request(seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_request(seg(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
        send_request(seg(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        send_request(seg(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_request(seg(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_request(seg(21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845));
        send_request(seg(-32768, 32767, 32767, 32767, 0, -32768, 0, 32767));
    endtask

    task automatic test_random_pairs(input int count);
        t_seg_pair r;
        int kind;
        int k;
        int j;
        repeat (count) begin
            kind = $urandom_range(0, 19);
            r.ax = rand_coord(kind < 8);
            r.ay = rand_coord(kind < 8);
            r.bx = rand_coord(kind < 8);
            r.by = rand_coord(kind < 8);
            r.cx = rand_coord(kind < 8);
            r.cy = rand_coord(kind < 8);
            r.ex = rand_coord(kind < 8);
            r.ey = rand_coord(kind < 8);
            k = int'($urandom_range(0, 6)) - 3;
            j = int'($urandom_range(0, 6)) - 3;
            case (kind)
                12, 13: begin
                    // parallel second segment
                    r.ex = t_coord'(r.cx + k * ($signed(r.bx) - $signed(r.ax)));
                    r.ey = t_coord'(r.cy + k * ($signed(r.by) - $signed(r.ay)));
                end
                14: begin
                    // collinear
                    r.cx = t_coord'(r.ax + j * ($signed(r.bx) - $signed(r.ax)));
                    r.cy = t_coord'(r.ay + j * ($signed(r.by) - $signed(r.ay)));
                    r.ex = t_coord'(r.cx + k * ($signed(r.bx) - $signed(r.ax)));
                    r.ey = t_coord'(r.cy + k * ($signed(r.by) - $signed(r.ay)));
                end
                15, 16: begin
                    r.cx = r.bx;
                    r.cy = r.by;
                end
                17: begin
                    r.ex = r.ax;
                    r.ey = r.ay;
                end
                18: begin
                    r.bx = r.ax;
                    r.by = r.ay;
                end
                19: begin
                    r.ax = ($urandom_range(0, 1) != 0) ? t_coord'(-32768) : t_coord'(32767);
                    r.ey = ($urandom_range(0, 1) != 0) ? t_coord'(-32768) : t_coord'(32767);
                end
                default: ;
            endcase
            send_request(r);
        end
    endtask

    task automatic test_pause_for_results();
        test_random_pairs(30);
        wait_all_results();
        test_random_pairs(30);
    endtask

    // receive side stall pattern
    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin : stall_loop
            int hold;
            hold = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            @(negedge i_clk);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!(o_valid && !i_stall)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : check_result
        t_crossing want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (crossing_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: hit=%0d t1=%0d t2=%0d",
                             o_hit, o_first_param, o_second_param);
            end else begin
                want = crossing_q.pop_front();
                if (o_hit !== want.hit || o_first_param !== want.t1 ||
                    o_second_param !== want.t2) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 want.hit, want.t1, want.t2,
                                 o_hit, o_first_param, o_second_param);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_first_start_x  = '0;
        i_first_start_y  = '0;
        i_first_end_x    = '0;
        i_first_end_y    = '0;
        i_second_start_x = '0;
        i_second_start_y = '0;
        i_second_end_x   = '0;
        i_second_end_y   = '0;
        mismatch_count   = 0;
        idle_on          = 1'b1;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_hits();
        test_directed_misses();
        test_coordinate_extremes();
        wait_all_results();

        test_random_pairs(700);
        test_pause_for_results();

        // back-to-back requests, no stalls
        idle_on = 1'b0;
        test_random_pairs(400);
        idle_on = 1'b1;

        test_random_pairs(450);
        wait_all_results();

        if (mismatch_count == 0 && crossing_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
